@@ sv/deq_pkg.sv @@
`default_nettype none

package deq_pkg;

  // widths of the channel fields
  localparam int CMD_W       = 3;
  localparam int VAL_FIELD_W = 64;
  localparam int CNT_FIELD_W = 7;
  localparam int STAT_W      = 2;

  // command codes; the two unused codes behave as a query
  typedef enum logic [CMD_W-1:0] {
    CMD_QUERY      = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_PUSH_BACK  = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4,
    CMD_REVERSE    = 3'd5
  } cmd_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // what every cell of one chain does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,  // keep the entry
    CELL_SHR  = 2'd1,  // take the lower neighbor's entry, cell 0 takes the pushed value
    CELL_SHL  = 2'd2,  // take the upper neighbor's entry
    CELL_PUT  = 2'd3   // the cell at the tail index takes the pushed value
  } cell_op_t;

  // broadcast control for both chains
  typedef struct packed {
    cell_op_t f_op;  // chain with the physical front at cell 0
    cell_op_t b_op;  // chain with the physical back at cell 0
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/deq_if.sv @@
`default_nettype none

// command channel
interface deq_in_if;
  import deq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       command;
  logic [VAL_FIELD_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

// result channel
interface deq_out_if;
  import deq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [VAL_FIELD_W-1:0] front_value;
  logic [VAL_FIELD_W-1:0] back_value;
  logic [CNT_FIELD_W-1:0] count;
  logic                   is_empty;
  logic [STAT_W-1:0]      status;

  modport source (output valid, output front_value, output back_value, output count,
                  output is_empty, output status, input ready);
  modport sink   (input valid, input front_value, input back_value, input count,
                  input is_empty, input status, output ready);
endinterface

`default_nettype wire

@@ sv/double_ended_queue_unit.sv @@
`default_nettype none

// Bounded double-ended queue of DEPTH values of VALUE_BITS bits each. Every command beat
// (query, push front, push back, pop front, pop back, reverse) yields one result beat with
// the front and back values, count, empty flag and status as they stand after the command.
// A new command is taken in every cycle while the result register is free or being drained,
// so the sustained rate is one command per clock. The elements sit in two rows of DEPTH
// cells, one ordered from the physical front and one from the physical back; a push shifts
// one row by one cell and puts the pushed value into the tail cell of the other; a pop shifts
// one row back, so both ends are always read from cell 0 of a row. Reverse only flips the
// orientation flag. A push when full or a pop when empty leaves the contents as they were.
module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  deq_in_if.sink     in_ch,
  deq_out_if.source  out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                  accept;
  logic                  out_valid_r, out_valid_nxt;
  cell_ctrl_t            ctrl;
  logic [CNT_W-1:0]      count;
  logic                  reversed;
  status_t               status;
  logic [VALUE_BITS-1:0] push_value;
  logic [VALUE_BITS-1:0] f_q [DEPTH];
  logic [VALUE_BITS-1:0] b_q [DEPTH];
  logic [VALUE_BITS-1:0] front_v, back_v;
  logic                  empty;

  // handshake: a command enters when the result slot is free or drains this cycle
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_value  = in_ch.value[VALUE_BITS-1:0];

  deq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .command  (in_ch.command),
    .ctrl     (ctrl),
    .count    (count),
    .reversed (reversed),
    .status   (status)
  );

  // row of cells, each linked to both neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_BITS-1:0] lo_f, lo_b, hi_f, hi_b;

    if (i == 0) begin : g_first
      assign lo_f = push_value;
      assign lo_b = push_value;
    end else begin : g_mid_lo
      assign lo_f = f_q[i-1];
      assign lo_b = b_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign hi_f = f_q[i];
      assign hi_b = b_q[i];
    end else begin : g_mid_hi
      assign hi_f = f_q[i+1];
      assign hi_b = b_q[i+1];
    end

    deq_cell #(
      .VALUE_BITS (VALUE_BITS),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count),
      .push_value (push_value),
      .lo_f       (lo_f),
      .lo_b       (lo_b),
      .hi_f       (hi_f),
      .hi_b       (hi_b),
      .f_q        (f_q[i]),
      .b_q        (b_q[i])
    );
  end

  // result beat valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload straight from the state, which only moves on an accepted command
  assign empty   = (count == '0);
  assign front_v = empty ? '0 : (reversed ? b_q[0] : f_q[0]);
  assign back_v  = empty ? '0 : (reversed ? f_q[0] : b_q[0]);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.front_value = VAL_FIELD_W'(front_v);
  assign out_ch.back_value  = VAL_FIELD_W'(back_v);
  assign out_ch.count       = CNT_FIELD_W'(count);
  assign out_ch.is_empty    = empty;
  assign out_ch.status      = status;

`ifndef SYNTHESIS
  // the count never runs past the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CNT_W'(DEPTH))
    else $error("element count above capacity");

  // a pop on an empty queue is refused and leaves it empty
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    accept && empty && (in_ch.command == CMD_POP_FRONT || in_ch.command == CMD_POP_BACK)
    |=> status == ST_EMPTY && count == '0)
    else $error("pop on empty queue not refused");

  // a push with room grows the count by one
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && count != CNT_W'(DEPTH)
      && (in_ch.command == CMD_PUSH_FRONT || in_ch.command == CMD_PUSH_BACK)
    |=> count == $past(count) + 1'b1 && status == ST_OK)
    else $error("push did not add one element");

  // every accepted command leaves a result beat pending
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted command produced no result");
`endif

endmodule

`default_nettype wire

@@ sv/deq_cell.sv @@
`default_nettype none

module deq_cell
  import deq_pkg::*;
#(
  parameter int VALUE_BITS = 64,
  parameter int CNT_W      = 7,
  parameter int IDX        = 0
) (
  input  wire logic                  clk,
  input  wire cell_ctrl_t            ctrl,
  input  wire logic [CNT_W-1:0]      count,
  input  wire logic [VALUE_BITS-1:0] push_value,
  input  wire logic [VALUE_BITS-1:0] lo_f,
  input  wire logic [VALUE_BITS-1:0] lo_b,
  input  wire logic [VALUE_BITS-1:0] hi_f,
  input  wire logic [VALUE_BITS-1:0] hi_b,
  output logic      [VALUE_BITS-1:0] f_q,
  output logic      [VALUE_BITS-1:0] b_q
);

  logic [VALUE_BITS-1:0] f_r, f_nxt;
  logic [VALUE_BITS-1:0] b_r, b_nxt;
  logic                  at_tail;

  // this cell is the first free slot past the occupied span
  assign at_tail = (count == CNT_W'(IDX));

  // one entry step for a chain
  function automatic logic [VALUE_BITS-1:0] step(
    input cell_op_t              op,
    input logic [VALUE_BITS-1:0] cur,
    input logic [VALUE_BITS-1:0] lo,
    input logic [VALUE_BITS-1:0] hi,
    input logic [VALUE_BITS-1:0] pv,
    input logic                  tail
  );
    logic [VALUE_BITS-1:0] res;
    res = cur;
    case (op)
      CELL_SHR: res = lo;
      CELL_SHL: res = hi;
      CELL_PUT: res = tail ? pv : cur;
      default:  res = cur;
    endcase
    return res;
  endfunction

  // next entries of both chains
  always_comb begin
    f_nxt = step(ctrl.f_op, f_r, lo_f, hi_f, push_value, at_tail);
    b_nxt = step(ctrl.b_op, b_r, lo_b, hi_b, push_value, at_tail);
  end

  // entry registers, no reset
  always_ff @(posedge clk) begin
    f_r <= f_nxt;
    b_r <= b_nxt;
  end

  assign f_q = f_r;
  assign b_q = b_r;

endmodule

`default_nettype wire

@@ sv/deq_ctrl.sv @@
`default_nettype none

module deq_ctrl
  import deq_pkg::*;
#(
  parameter  int DEPTH = 64,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [CMD_W-1:0] command,
  output cell_ctrl_t            ctrl,
  output logic      [CNT_W-1:0] count,
  output logic                  reversed,
  output status_t               status
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             rev_r, rev_nxt;
  status_t          status_r, status_nxt;
  logic             full, empty, phys_front;
  cmd_t             cmd;

  assign cmd   = cmd_t'(command);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // decode one command into chain operations and the new count and orientation
  always_comb begin
    count_nxt   = count_r;
    rev_nxt     = rev_r;
    status_nxt  = status_r;
    ctrl.f_op   = CELL_HOLD;
    ctrl.b_op   = CELL_HOLD;
    phys_front  = 1'b0;
    if (accept) begin
      status_nxt = ST_OK;
      case (cmd)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          phys_front = (cmd == CMD_PUSH_FRONT) != rev_r;
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            ctrl.f_op = phys_front ? CELL_SHR : CELL_PUT;
            ctrl.b_op = phys_front ? CELL_PUT : CELL_SHR;
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          phys_front = (cmd == CMD_POP_FRONT) != rev_r;
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            ctrl.f_op = phys_front ? CELL_SHL : CELL_HOLD;
            ctrl.b_op = phys_front ? CELL_HOLD : CELL_SHL;
            count_nxt = count_r - 1'b1;
          end
        end
        CMD_REVERSE: begin
          rev_nxt = !rev_r;
        end
        default: begin
        end
      endcase
    end
  end

  // span and orientation registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rev_r    <= 1'b0;
      status_r <= ST_OK;
    end else begin
      count_r  <= count_nxt;
      rev_r    <= rev_nxt;
      status_r <= status_nxt;
    end
  end

  assign count    = count_r;
  assign reversed = rev_r;
  assign status   = status_r;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none

module tb;
  import deq_pkg::*;

  localparam int DEPTH       = 64;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int ITEMS       = 1950;
  localparam int BLOCK_ITEMS = 150;
  localparam int LONG_HOLD   = 300;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 8;

  // command codes without a name in the package; the block treats them as a query
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef enum int {MIX_FILL, MIX_EVEN, MIX_DRAIN} cmd_mix_t;

  typedef struct packed {
    logic [VAL_FIELD_W-1:0] front_value;
    logic [VAL_FIELD_W-1:0] back_value;
    logic [CNT_FIELD_W-1:0] count;
    logic                   is_empty;
    logic [STAT_W-1:0]      status;
  } deq_result_t;

  // shadow copy of the deque and the results it still owes
  class deque_shadow;
    logic [VAL_FIELD_W-1:0] slots [DEPTH];
    logic [IDX_W-1:0]       head;
    int unsigned            used;
    bit                     flipped;
    deq_result_t            owed_q [$];
    int                     errors;

    function new();
      head    = '0;
      used    = 0;
      flipped = 1'b0;
      errors  = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // apply one accepted command beat and queue the result it must produce
    function void note_command(logic [CMD_W-1:0] code, logic [VAL_FIELD_W-1:0] data);
      status_t                st;
      bit                     at_head;
      logic [IDX_W-1:0]       tail_idx;
      logic [VAL_FIELD_W-1:0] head_val;
      logic [VAL_FIELD_W-1:0] tail_val;
      deq_result_t            r;
      st = ST_OK;
      case (code)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (used >= DEPTH) begin
            st = ST_FULL;
          end else begin
            at_head = (code == CMD_PUSH_FRONT) != flipped;
            if (at_head) begin
              head = head - 1'b1;
              slots[head] = data;
            end else begin
              tail_idx = head + used[IDX_W-1:0];
              slots[tail_idx] = data;
            end
            used++;
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (used == 0) begin
            st = ST_EMPTY;
          end else begin
            at_head = (code == CMD_POP_FRONT) != flipped;
            if (at_head) head = head + 1'b1;
            used--;
          end
        end
        CMD_REVERSE: flipped = !flipped;
        default: ;
      endcase

      // ends as seen after the command
      head_val = '0;
      tail_val = '0;
      if (used != 0) begin
        tail_idx = head + used[IDX_W-1:0] - 1'b1;
        head_val = slots[head];
        tail_val = slots[tail_idx];
      end
      r.front_value = flipped ? tail_val : head_val;
      r.back_value  = flipped ? head_val : tail_val;
      r.count       = used[CNT_FIELD_W-1:0];
      r.is_empty    = (used == 0);
      r.status      = st;
      owed_q.push_back(r);
    endfunction

    // compare one result beat with the oldest owed result
    function void check_result(deq_result_t got);
      deq_result_t want;
      if (owed_q.size() == 0) begin
        $error("result beat with no command outstanding");
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.front_value !== want.front_value) begin
        $error("front_value: expected %h, actual %h", want.front_value, got.front_value);
        errors++;
      end
      if (got.back_value !== want.back_value) begin
        $error("back_value: expected %h, actual %h", want.back_value, got.back_value);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, actual %0d", want.count, got.count);
        errors++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0d, actual %0d", want.is_empty, got.is_empty);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  deq_in_if  in_ch ();
  deq_out_if out_ch ();

  double_ended_queue_unit #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VAL_FIELD_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  deque_shadow shadow = new();
  bit quiet         = 1'b0;
  bit long_hold_req = 1'b0;
  int sent          = 0;
  int idle_cycles   = 0;

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // gap length: mostly short, now and then long
  function automatic int gap_len();
    if ($urandom_range(9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VAL_FIELD_W-1:0] rand_value();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // command drawn with a push/pop balance that fills, holds or drains the deque
  function automatic logic [CMD_W-1:0] rand_command(cmd_mix_t mix);
    int pick;
    int push_pct;
    int pop_pct;
    pick = $urandom_range(99);
    case (mix)
      MIX_FILL:  begin push_pct = 70; pop_pct = 15; end
      MIX_DRAIN: begin push_pct = 15; pop_pct = 70; end
      default:   begin push_pct = 42; pop_pct = 42; end
    endcase
    if (pick < push_pct)
      return $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    if (pick < push_pct + pop_pct)
      return $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
    pick = $urandom_range(9);
    if (pick < 5) return CMD_REVERSE;
    if (pick < 8) return CMD_QUERY;
    return (pick == 8) ? CMD_SPARE_6 : CMD_SPARE_7;
  endfunction

  task automatic pause_sender(input int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // offer one command beat, wait for it to be taken, then maybe idle
  task automatic issue(input logic [CMD_W-1:0] code, input logic [VAL_FIELD_W-1:0] data);
    in_ch.valid   <= 1'b1;
    in_ch.command <= code;
    in_ch.value   <= data;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    if (!quiet && $urandom_range(2) == 0) pause_sender(gap_len());
  endtask

  // wait for a clock edge first so the last accepted beat is already in the scoreboard
  task automatic wait_drained();
    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  // result side back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(3) == 0) begin
        stall_left = gap_len() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // beat monitor, prediction, checking and watchdog
  always @(posedge clk) begin : monitor
    deq_result_t seen;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        shadow.note_command(in_ch.command, in_ch.value);
      if (out_ch.valid && out_ch.ready) begin
        seen.front_value = out_ch.front_value;
        seen.back_value  = out_ch.back_value;
        seen.count       = out_ch.count;
        seen.is_empty    = out_ch.is_empty;
        seen.status      = out_ch.status;
        shadow.check_result(seen);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int       blk;
    cmd_mix_t mix;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.command <= CMD_QUERY;
    in_ch.value   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-deque errors, reverse when empty, value extremes,
    // both ends in both orientations, spare codes
    issue(CMD_QUERY, '0);
    issue(CMD_POP_FRONT, '1);
    issue(CMD_POP_BACK, '0);
    issue(CMD_REVERSE, '0);
    issue(CMD_PUSH_FRONT, '0);
    issue(CMD_PUSH_BACK, '1);
    issue(CMD_REVERSE, '1);
    issue(CMD_PUSH_FRONT, 64'hAAAA_AAAA_AAAA_AAAA);
    issue(CMD_PUSH_BACK, 64'h5555_5555_5555_5555);
    issue(CMD_SPARE_6, '1);
    issue(CMD_SPARE_7, 64'h8000_0000_0000_0001);
    issue(CMD_POP_FRONT, '1);
    issue(CMD_POP_BACK, '0);
    issue(CMD_REVERSE, '0);
    issue(CMD_POP_FRONT, '0);
    issue(CMD_POP_BACK, '0);
    issue(CMD_POP_BACK, '1);
    issue(CMD_POP_FRONT, '0);
    issue(CMD_REVERSE, '0);
    issue(CMD_QUERY, '1);

    // random blocks cycling through fill, even and drain so both bounds get hit
    blk = 0;
    while (sent < ITEMS) begin
      case (blk % 3)
        0:       mix = MIX_FILL;
        1:       mix = MIX_EVEN;
        default: mix = MIX_DRAIN;
      endcase
      quiet = (blk % 4 == 3);
      // receiver holds off for a long stretch while commands keep coming
      if (blk == 2) long_hold_req = 1'b1;
      // sender waits for every outstanding result
      if (blk == 5) begin
        pause_sender(0);
        wait_drained();
      end
      repeat (BLOCK_ITEMS) issue(rand_command(mix), rand_value());
      blk++;
    end

    pause_sender(0);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
